// ----- src/vrle_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vrle_pkg: shared definitions for the voxel run-length group decoder
// Widths, format constants and the coordinate bundle used across modules.
// ----------------------------------------------------------------------------
package vrle_pkg;

  localparam int unsigned LG_W    = 3;
  localparam int unsigned IDX_W   = 15;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned LEFT_W  = 9;

  localparam logic [LG_W-1:0] MAX_NODE_LOG2 = 3'd5;
  localparam logic [7:0]      REPEAT_MARK   = 8'h80;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } vrle_coord_t;

endpackage
`default_nettype wire

// ----- src/vrle_req_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vrle_req_if: request channel of the voxel run-length group decoder
// Valid/ready channel carrying one coded byte or one patch start.
// ----------------------------------------------------------------------------
interface vrle_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [7:0]  data_byte;
  logic [15:0] origin_x;
  logic [15:0] origin_y;
  logic [15:0] origin_z;

  modport source (
    output valid, req_type, data_byte, origin_x, origin_y, origin_z,
    input  ready
  );
  modport sink (
    input  valid, req_type, data_byte, origin_x, origin_y, origin_z,
    output ready
  );
endinterface
`default_nettype wire

// ----- src/vrle_run_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vrle_run_if: run channel of the voxel run-length group decoder
// Valid/ready channel carrying one decoded run with its start coordinates.
// ----------------------------------------------------------------------------
interface vrle_run_if;
  logic               valid;
  logic               ready;
  logic signed [7:0]  run_texture;
  logic signed [7:0]  run_value;
  logic [7:0]         run_length;
  logic [14:0]        start_index;
  logic [15:0]        voxel_x;
  logic [15:0]        voxel_y;
  logic [15:0]        voxel_z;

  modport source (
    output valid, run_texture, run_value, run_length, start_index,
           voxel_x, voxel_y, voxel_z,
    input  ready
  );
  modport sink (
    input  valid, run_texture, run_value, run_length, start_index,
           voxel_x, voxel_y, voxel_z,
    output ready
  );
endinterface
`default_nettype wire

// ----- src/vrle_coord.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vrle_coord: voxel index to absolute coordinates
// Splits a linear patch index by the node size and adds the patch origin.
// ----------------------------------------------------------------------------
module vrle_coord (
  input  wire logic [vrle_pkg::IDX_W-1:0] idx_i,
  input  wire logic [vrle_pkg::LG_W-1:0]  lg_i,
  input  wire vrle_pkg::vrle_coord_t      origin_i,
  output      vrle_pkg::vrle_coord_t      pos_o
);

  logic [vrle_pkg::LG_W-1:0]  lg;
  logic [vrle_pkg::LG_W:0]    sh2;
  logic [vrle_pkg::IDX_W-1:0] mask;
  logic [vrle_pkg::IDX_W-1:0] px;
  logic [vrle_pkg::IDX_W-1:0] py;
  logic [vrle_pkg::IDX_W-1:0] pz;

  assign lg   = (lg_i > vrle_pkg::MAX_NODE_LOG2) ? vrle_pkg::MAX_NODE_LOG2 : lg_i;
  assign sh2  = {lg, 1'b0};
  assign mask = (vrle_pkg::IDX_W'(1) << lg) - vrle_pkg::IDX_W'(1);
  assign px   = idx_i >> sh2;
  assign py   = (idx_i >> lg) & mask;
  assign pz   = idx_i & mask;

  assign pos_o.x = origin_i.x + {1'b0, px};
  assign pos_o.y = origin_i.y + {1'b0, py};
  assign pos_o.z = origin_i.z + {1'b0, pz};

endmodule
`default_nettype wire

// ----- src/voxel_rle_group_decoder.sv -----
// Decodes a two-level run-length coded voxel byte stream, one request per
// clock cycle: the parser state advances in the cycle a request is accepted,
// and a run, if the byte completes one, appears in the output register on the
// next cycle. The output register alone sets the rate; the request side stalls
// only while a run is held there and the run side is not ready.
`default_nettype none
// ----------------------------------------------------------------------------
// voxel_rle_group_decoder: two-level run-length voxel decoder
// Parses group headers, counts, values and repeats into runs with coordinates.
// ----------------------------------------------------------------------------
module voxel_rle_group_decoder (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [vrle_pkg::LG_W-1:0] cfg_wdata_i,
  vrle_req_if.sink                       req_i,
  vrle_run_if.source                     run_o
);

  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_SINGLE  = 3'd1;
  localparam logic [2:0] PH_COUNT   = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_REPEAT  = 3'd4;

  logic [vrle_pkg::LG_W-1:0]   lg_q;
  logic [2:0]                  phase_q, phase_d;
  logic [vrle_pkg::LEFT_W-1:0] left_q, left_d;
  logic [7:0]                  tex_q, tex_d;
  logic [7:0]                  last_q, last_d;
  logic [vrle_pkg::IDX_W-1:0]  cnt_q, cnt_d;
  vrle_pkg::vrle_coord_t       origin_q, origin_d;

  logic                        emit;
  logic [7:0]                  emit_val;
  logic [7:0]                  emit_len;
  logic                        in_acc;
  logic [7:0]                  b;
  vrle_pkg::vrle_coord_t       pos;

  logic                        run_vld_q;
  logic [7:0]                  run_tex_q;
  logic [7:0]                  run_val_q;
  logic [7:0]                  run_len_q;
  logic [vrle_pkg::IDX_W-1:0]  run_idx_q;
  vrle_pkg::vrle_coord_t       run_pos_q;

  assign b           = req_i.data_byte;
  assign req_i.ready = !run_vld_q || run_o.ready;
  assign in_acc      = req_i.valid && req_i.ready;

  always_comb begin
    phase_d  = phase_q;
    left_d   = left_q;
    tex_d    = tex_q;
    last_d   = last_q;
    origin_d = origin_q;
    emit     = 1'b0;
    emit_val = b;
    emit_len = 8'd1;
    if (req_i.req_type) begin
      phase_d    = PH_HEADER;
      left_d     = '0;
      tex_d      = '0;
      last_d     = '0;
      origin_d.x = req_i.origin_x;
      origin_d.y = req_i.origin_y;
      origin_d.z = req_i.origin_z;
    end else begin
      unique case (phase_q)
        PH_HEADER: begin
          if (b[7]) begin
            tex_d   = ~b;
            phase_d = PH_COUNT;
          end else begin
            tex_d   = b - 8'd1;
            phase_d = PH_SINGLE;
          end
        end
        PH_SINGLE: begin
          last_d  = b;
          emit    = 1'b1;
          phase_d = PH_HEADER;
        end
        PH_COUNT: begin
          left_d  = {1'b0, b} + 9'd1;
          phase_d = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          if (b == vrle_pkg::REPEAT_MARK) begin
            phase_d = PH_REPEAT;
          end else begin
            last_d  = b;
            emit    = 1'b1;
            left_d  = (left_q != '0) ? left_q - 9'd1 : '0;
            phase_d = (left_d != '0) ? PH_PAYLOAD : PH_HEADER;
          end
        end
        PH_REPEAT: begin
          emit     = 1'b1;
          emit_val = last_q;
          emit_len = b;
          left_d   = (left_q >= 9'd2) ? left_q - 9'd2 : '0;
          phase_d  = (left_d != '0) ? PH_PAYLOAD : PH_HEADER;
        end
        default: begin
          phase_d = PH_HEADER;
        end
      endcase
    end
  end

  always_comb begin
    if (req_i.req_type) begin
      cnt_d = '0;
    end else if (emit) begin
      cnt_d = cnt_q + {7'd0, emit_len};
    end else begin
      cnt_d = cnt_q;
    end
  end

  vrle_coord u_coord (
    .idx_i    (cnt_q),
    .lg_i     (lg_q),
    .origin_i (origin_q),
    .pos_o    (pos)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lg_q <= 3'd4;
    end else if (cfg_we_i) begin
      lg_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      left_q   <= '0;
      tex_q    <= '0;
      last_q   <= '0;
      cnt_q    <= '0;
      origin_q <= '0;
    end else if (in_acc) begin
      phase_q  <= phase_d;
      left_q   <= left_d;
      tex_q    <= tex_d;
      last_q   <= last_d;
      cnt_q    <= cnt_d;
      origin_q <= origin_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_vld_q <= 1'b0;
    end else if (in_acc) begin
      run_vld_q <= emit;
    end else if (run_o.ready) begin
      run_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && emit) begin
      run_tex_q <= tex_q;
      run_val_q <= emit_val;
      run_len_q <= emit_len;
      run_idx_q <= cnt_q;
      run_pos_q <= pos;
    end
  end

  assign run_o.valid       = run_vld_q;
  assign run_o.run_texture = run_tex_q;
  assign run_o.run_value   = run_val_q;
  assign run_o.run_length  = run_len_q;
  assign run_o.start_index = run_idx_q;
  assign run_o.voxel_x     = run_pos_q.x;
  assign run_o.voxel_y     = run_pos_q.y;
  assign run_o.voxel_z     = run_pos_q.z;

`ifndef SYNTHESIS
  a_payload_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> left_q != '0)
    else $error("payload phase with no payload slots left");

  a_patch_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && req_i.req_type |=> phase_q == PH_HEADER && cnt_q == '0)
    else $error("patch start did not clear the parser");

  a_single_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !req_i.req_type && phase_q == PH_SINGLE
      |=> run_o.valid && run_o.run_length == 8'd1)
    else $error("single value did not produce a run of length one");
`endif

endmodule
`default_nettype wire
